// ----- rtl/core/gve_pkg.sv -----
package gve_pkg;

  // Fixed-point layout of the kept estimate
  localparam int STATE_FRAC_BITS = 28;
  localparam int OUT_SHIFT       = STATE_FRAC_BITS - 12;
  localparam int DIV_QBITS       = STATE_FRAC_BITS + 2;
  localparam int DIV_NUM_W       = 16 + STATE_FRAC_BITS + 15;
  localparam int SQRT_STEPS      = 31;
  localparam int ROT_SHIFT       = 34;
  localparam int BLEND_SHIFT     = 32;

  localparam logic signed [31:0] G_ONE = 32'sd1 <<< STATE_FRAC_BITS;

  // Register indexes and reset values
  localparam logic [2:0] REG_DT_STEP  = 3'd0;
  localparam logic [2:0] REG_WEIGHT   = 3'd1;
  localparam logic [2:0] REG_MAG_LOW  = 3'd2;
  localparam logic [2:0] REG_MAG_HIGH = 3'd3;

  localparam logic [15:0] DT_RESET     = 16'd4194;
  localparam logic [23:0] WEIGHT_RESET = 24'd42710;
  localparam logic [14:0] MLO_RESET    = 15'd2867;
  localparam logic [14:0] MHI_RESET    = 15'd5325;

  // Datapath operations
  localparam logic [4:0] OP_NOP       = 5'd0;
  localparam logic [4:0] OP_LOAD      = 5'd1;
  localparam logic [4:0] OP_ANG       = 5'd2;
  localparam logic [4:0] OP_RMUL      = 5'd3;
  localparam logic [4:0] OP_RACC      = 5'd4;
  localparam logic [4:0] OP_SQ        = 5'd5;
  localparam logic [4:0] OP_SACC      = 5'd6;
  localparam logic [4:0] OP_LSQ       = 5'd7;
  localparam logic [4:0] OP_LCMP      = 5'd8;
  localparam logic [4:0] OP_HSQ       = 5'd9;
  localparam logic [4:0] OP_HCMP      = 5'd10;
  localparam logic [4:0] OP_SQRT_INIT = 5'd11;
  localparam logic [4:0] OP_SQRT_STEP = 5'd12;
  localparam logic [4:0] OP_DIV_INIT  = 5'd13;
  localparam logic [4:0] OP_DIV_STEP  = 5'd14;
  localparam logic [4:0] OP_DIFF      = 5'd15;
  localparam logic [4:0] OP_BMUL      = 5'd16;
  localparam logic [4:0] OP_BACC      = 5'd17;
  localparam logic [4:0] OP_OUT       = 5'd18;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] sel;   // axis for angle, square, divide, blend
    logic [1:0] src;   // rotation: component multiplied
    logic [1:0] dst;   // rotation: component updated
    logic       neg;   // rotation: negate angle before multiply
    logic       sub;   // rotation: subtract rounded term
  } gve_cmd_t;

  typedef struct packed {
    logic used;
    logic out_busy;
  } gve_sts_t;

  // Rotation sequence: X turn, then Y turn, then Z turn, two updates each
  function automatic logic [1:0] rot_axis(input logic [2:0] step);
    logic [1:0] r;
    case (step)
      3'd0, 3'd1: r = 2'd0;
      3'd2, 3'd3: r = 2'd1;
      default:    r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] rot_src(input logic [2:0] step);
    logic [1:0] r;
    case (step)
      3'd0:       r = 2'd0;
      3'd1, 3'd2: r = 2'd2;
      3'd3, 3'd4: r = 2'd1;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] rot_dst(input logic [2:0] step);
    logic [1:0] r;
    case (step)
      3'd0, 3'd3: r = 2'd2;
      3'd1, 3'd4: r = 2'd0;
      default:    r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    logic signed [15:0] r;
    if (v > 34'sd32767) r = 16'sh7FFF;
    else if (v < -34'sd32768) r = -16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ----- rtl/core/gve_datapath.sv -----
module gve_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [23:0]          cfg_wdata,
  input  logic [95:0]          in_tdata,
  input  gve_pkg::gve_cmd_t    cmd,
  output gve_pkg::gve_sts_t    sts,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [47:0]          out_tdata,
  output logic                 out_tuser
);
  import gve_pkg::*;

  logic [15:0] dt_r;
  logic [23:0] weight_r;
  logic [14:0] mlo_r, mhi_r;

  logic signed [15:0] rate_r [3];
  logic signed [15:0] acc_r  [3];
  logic signed [31:0] g_r    [3];
  logic signed [32:0] ang_r;
  logic signed [65:0] prod_r;
  logic [31:0] s_r;
  logic        used_r;
  logic [31:0] sq_n_r;
  logic [31:0] sq_rem_r;
  logic [30:0] root_r;
  logic [31:0] dv_rem_r;
  logic [DIV_QBITS-1:0] dv_low_r;
  logic [DIV_QBITS-1:0] q_r;
  logic signed [32:0] diff_r;
  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic        out_used_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [65:0] rot_rnd, bl_rnd;
  logic signed [33:0] rot_sum, bl_sum;
  logic [33:0] sq_rem2, sq_trial;
  logic [32:0] dv_rem2;
  logic [15:0] acc_mag;
  logic [DIV_NUM_W-1:0] dv_num;
  logic signed [32:0] norm;
  logic signed [33:0] grnd [3];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r     <= DT_RESET;
      weight_r <= WEIGHT_RESET;
      mlo_r    <= MLO_RESET;
      mhi_r    <= MHI_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DT_STEP:  dt_r     <= cfg_wdata[15:0];
        REG_WEIGHT:   weight_r <= cfg_wdata;
        REG_MAG_LOW:  mlo_r    <= cfg_wdata[14:0];
        REG_MAG_HIGH: mhi_r    <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_ANG: begin
        mul_a = 33'(rate_r[cmd.sel]);
        mul_b = $signed({17'd0, dt_r});
      end
      OP_RMUL: begin
        mul_a = cmd.neg ? -ang_r : ang_r;
        mul_b = 33'(g_r[cmd.src]);
      end
      OP_SQ: begin
        mul_a = 33'(acc_r[cmd.sel]);
        mul_b = 33'(acc_r[cmd.sel]);
      end
      OP_LSQ: begin
        mul_a = $signed({18'd0, mlo_r});
        mul_b = $signed({18'd0, mlo_r});
      end
      OP_HSQ: begin
        mul_a = $signed({18'd0, mhi_r});
        mul_b = $signed({18'd0, mhi_r});
      end
      OP_BMUL: begin
        mul_a = diff_r;
        mul_b = $signed({9'd0, weight_r});
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Rotation and blend rounding, add and saturate
  assign rot_rnd = (prod_r + (66'sd1 <<< (ROT_SHIFT - 1))) >>> ROT_SHIFT;
  assign rot_sum = cmd.sub ? (34'(g_r[cmd.dst]) - rot_rnd[33:0])
                           : (34'(g_r[cmd.dst]) + rot_rnd[33:0]);
  assign bl_rnd  = (prod_r + (66'sd1 <<< (BLEND_SHIFT - 1))) >>> BLEND_SHIFT;
  assign bl_sum  = 34'(g_r[cmd.sel]) + bl_rnd[33:0];

  // Square root digit step: two radicand bits per step
  assign sq_rem2  = {sq_rem_r, sq_n_r[31:30]};
  assign sq_trial = {1'b0, root_r, 2'b01};

  // Divide: magnitude scaled up, plus half the divisor for rounding
  assign acc_mag = acc_r[cmd.sel][15] ? 16'(-acc_r[cmd.sel]) : acc_r[cmd.sel];
  assign dv_num  = (DIV_NUM_W'(acc_mag) << (STATE_FRAC_BITS + 15))
                 + DIV_NUM_W'(root_r >> 1);
  assign dv_rem2 = {dv_rem_r, dv_low_r[DIV_QBITS-1]};
  assign norm    = acc_r[cmd.sel][15] ? -$signed(33'(q_r)) : $signed(33'(q_r));

  // Output rounding of the estimate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      grnd[i] = (34'(g_r[i]) + (34'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    end
  end

  // Estimate state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_r[0] <= '0;
      g_r[1] <= '0;
      g_r[2] <= G_ONE;
    end else begin
      case (cmd.op)
        OP_RACC: g_r[cmd.dst] <= sat32(rot_sum);
        OP_BACC: g_r[cmd.sel] <= sat32(bl_sum);
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        rate_r[0] <= in_tdata[15:0];
        rate_r[1] <= in_tdata[31:16];
        rate_r[2] <= in_tdata[47:32];
        acc_r[0]  <= in_tdata[63:48];
        acc_r[1]  <= in_tdata[79:64];
        acc_r[2]  <= in_tdata[95:80];
        s_r       <= '0;
      end
      OP_ANG:  ang_r  <= mul_p[32:0];
      OP_RMUL, OP_SQ, OP_LSQ, OP_HSQ, OP_BMUL: prod_r <= mul_p;
      OP_SACC: s_r    <= s_r + prod_r[31:0];
      OP_SQRT_INIT: begin
        sq_n_r   <= s_r;
        sq_rem_r <= '0;
        root_r   <= '0;
      end
      OP_SQRT_STEP: begin
        sq_n_r <= {sq_n_r[29:0], 2'b00};
        if (sq_rem2 >= sq_trial) begin
          sq_rem_r <= 32'(sq_rem2 - sq_trial);
          root_r   <= {root_r[29:0], 1'b1};
        end else begin
          sq_rem_r <= sq_rem2[31:0];
          root_r   <= {root_r[29:0], 1'b0};
        end
      end
      OP_DIV_INIT: begin
        dv_rem_r <= 32'(dv_num[DIV_NUM_W-1:DIV_QBITS]);
        dv_low_r <= dv_num[DIV_QBITS-1:0];
        q_r      <= '0;
      end
      OP_DIV_STEP: begin
        dv_low_r <= {dv_low_r[DIV_QBITS-2:0], 1'b0};
        if (dv_rem2 >= {2'b00, root_r}) begin
          dv_rem_r <= 32'(dv_rem2 - {2'b00, root_r});
          q_r      <= {q_r[DIV_QBITS-2:0], 1'b1};
        end else begin
          dv_rem_r <= dv_rem2[31:0];
          q_r      <= {q_r[DIV_QBITS-2:0], 1'b0};
        end
      end
      OP_DIFF: diff_r <= norm - 33'(g_r[cmd.sel]);
      default: ;
    endcase
  end

  // Magnitude window test
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: used_r <= 1'b0;
        OP_LCMP: used_r <= s_r > prod_r[31:0];
        OP_HCMP: used_r <= used_r && (s_r < prod_r[31:0]);
        default: ;
      endcase
    end
  end

  // Output register: holds a finished result until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_data_r <= {sat16(grnd[2]), sat16(grnd[1]), sat16(grnd[0])};
      out_used_r <= used_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser    = out_used_r;
  assign sts.used     = used_r;
  assign sts.out_busy = out_valid_r && !out_tready;

endmodule

// ----- rtl/core/gve_ctrl.sv -----
module gve_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  gve_pkg::gve_sts_t  sts,
  output gve_pkg::gve_cmd_t  cmd
);
  import gve_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROT   = 3'd1;
  localparam logic [2:0] S_SQ    = 3'd2;
  localparam logic [2:0] S_LIM   = 3'd3;
  localparam logic [2:0] S_SQRT  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_BLEND = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      ph_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      ph_r    <= ph_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ph_nxt    = ph_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.op    = OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_ROT;
          step_nxt  = '0;
          ph_nxt    = '0;
        end
      end
      S_ROT: begin
        cmd.sel = rot_axis(step_r);
        cmd.src = rot_src(step_r);
        cmd.dst = rot_dst(step_r);
        cmd.neg = (step_r == 3'd3);
        cmd.sub = (step_r == 3'd0) || (step_r == 3'd4);
        case (ph_r)
          2'd0:    cmd.op = OP_ANG;
          2'd1:    cmd.op = OP_RMUL;
          default: cmd.op = OP_RACC;
        endcase
        if (ph_r == 2'd2) begin
          ph_nxt = '0;
          if (step_r == 3'd5) begin
            step_nxt  = '0;
            state_nxt = S_SQ;
          end else begin
            step_nxt = step_r + 3'd1;
          end
        end else begin
          ph_nxt = ph_r + 2'd1;
        end
      end
      S_SQ: begin
        cmd.sel = step_r[1:0];
        cmd.op  = (ph_r == 2'd0) ? OP_SQ : OP_SACC;
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else begin
          ph_nxt = '0;
          if (step_r == 3'd2) begin
            step_nxt  = '0;
            state_nxt = S_LIM;
          end else begin
            step_nxt = step_r + 3'd1;
          end
        end
      end
      S_LIM: begin
        case (ph_r)
          2'd0:    cmd.op = OP_LSQ;
          2'd1:    cmd.op = OP_LCMP;
          2'd2:    cmd.op = OP_HSQ;
          default: cmd.op = OP_HCMP;
        endcase
        ph_nxt = ph_r + 2'd1;
        if (ph_r == 2'd3) state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (ph_r == 2'd0) begin
          if (!sts.used) begin
            state_nxt = S_OUT;
          end else begin
            cmd.op  = OP_SQRT_INIT;
            ph_nxt  = 2'd1;
            cnt_nxt = '0;
          end
        end else begin
          cmd.op  = OP_SQRT_STEP;
          cnt_nxt = cnt_r + 5'd1;
          if (cnt_r == 5'(SQRT_STEPS - 1)) begin
            ph_nxt    = '0;
            step_nxt  = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.sel = step_r[1:0];
        if (ph_r == 2'd0) begin
          cmd.op  = OP_DIV_INIT;
          ph_nxt  = 2'd1;
          cnt_nxt = '0;
        end else begin
          cmd.op  = OP_DIV_STEP;
          cnt_nxt = cnt_r + 5'd1;
          if (cnt_r == 5'(DIV_QBITS - 1)) begin
            ph_nxt    = '0;
            state_nxt = S_BLEND;
          end
        end
      end
      S_BLEND: begin
        cmd.sel = step_r[1:0];
        case (ph_r)
          2'd0:    cmd.op = OP_DIFF;
          2'd1:    cmd.op = OP_BMUL;
          default: cmd.op = OP_BACC;
        endcase
        if (ph_r == 2'd2) begin
          ph_nxt = '0;
          if (step_r == 3'd2) begin
            state_nxt = S_OUT;
          end else begin
            step_nxt  = step_r + 3'd1;
            state_nxt = S_DIV;
          end
        end else begin
          ph_nxt = ph_r + 2'd1;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result is loaded only into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_OUT |-> !sts.out_busy)
    else $error("result loaded over an untaken result");

  // Square root starts only after the magnitude window passed
  a_sqrt_used: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_SQRT_INIT |-> sts.used)
    else $error("normalization started without a valid magnitude");

  // Last rotation update leads into the squares
  a_rot_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT && step_r == 3'd5 && ph_r == 2'd2) |=> state_r == S_SQ)
    else $error("rotation sequence did not hand over");

  // Input transfer starts the rotation
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_ROT && step_r == 3'd0))
    else $error("accepted item not started");

endmodule

// ----- rtl/core/gravity_vector_estimator_top.sv -----
// Outside the accel window only the rotation is applied; inside it the correction also
//   runs (31-step square root, 30-step divide per axis).
// Items are handled one at a time; the next item is taken while the result waits.
// Multiplies go one at a time through a single shared 33x33 multiplier.
// Reset (rst_n, synchronous, active low): estimate to (0, 0, 1 g), registers to defaults.
module gravity_vector_estimator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z (16 bits each, from bit 0)
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // grav_x, grav_y, grav_z (16 bits each, from bit 0)
  output logic [47:0] out_tdata,
  // accel_used
  output logic        out_tuser
);
  import gve_pkg::*;

  gve_cmd_t cmd;
  gve_sts_t sts;

  gve_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gve_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- tb/gve_checker.sv -----
`timescale 1ns / 100ps

module gve_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        out_tuser,
  output int          errors,
  output int          pending,
  output int          n_results,
  output int          n_corrected
);
  import gve_pkg::*;

  typedef struct packed {
    logic signed [15:0] gz;
    logic signed [15:0] gy;
    logic signed [15:0] gx;
    logic               used;
  } grav_t;

  // Shadow copy of the registers and of the kept estimate
  logic [15:0] dt_q;
  logic [23:0] weight_q;
  logic [14:0] mlo_q;
  logic [14:0] mhi_q;
  int          est [3];
  grav_t       grav_q [$];

  assign pending = grav_q.size();

  function automatic longint round_shr(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic int clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 64'sd32767) return 16'sh7FFF;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Turn by the gyro step, blend in the accel if its magnitude is in the window
  task automatic predict_gravity(input logic [95:0] d, output grav_t r);
    longint ang [3];
    longint acc [3];
    longint unsigned s, lo, hi, mfine, mag, q;
    longint norm, diff;
    logic used;
    for (int i = 0; i < 3; i++) begin
      ang[i] = longint'($signed(d[16*i +: 16])) * longint'(dt_q);
      acc[i] = longint'($signed(d[48 + 16*i +: 16]));
    end
    est[2] = clip32(longint'(est[2]) - round_shr(ang[0] * est[0], ROT_SHIFT));
    est[0] = clip32(longint'(est[0]) + round_shr(ang[0] * est[2], ROT_SHIFT));
    est[1] = clip32(longint'(est[1]) + round_shr(ang[1] * est[2], ROT_SHIFT));
    est[2] = clip32(longint'(est[2]) + round_shr(-ang[1] * est[1], ROT_SHIFT));
    est[0] = clip32(longint'(est[0]) - round_shr(ang[2] * est[1], ROT_SHIFT));
    est[1] = clip32(longint'(est[1]) + round_shr(ang[2] * est[0], ROT_SHIFT));

    s = 0;
    for (int i = 0; i < 3; i++) s += longint'(acc[i] * acc[i]);
    lo = longint'(mlo_q) * longint'(mlo_q);
    hi = longint'(mhi_q) * longint'(mhi_q);
    used = (s > lo) && (s < hi);
    if (used) begin
      mfine = int_sqrt(s << 30);
      for (int i = 0; i < 3; i++) begin
        mag = (acc[i] < 0) ? -acc[i] : acc[i];
        q = ((mag << (STATE_FRAC_BITS + 15)) + mfine / 2) / mfine;
        norm = (acc[i] < 0) ? -longint'(q) : longint'(q);
        diff = longint'(clip32(norm)) - longint'(est[i]);
        est[i] = clip32(longint'(est[i]) +
                        round_shr(diff * longint'(weight_q), BLEND_SHIFT));
      end
    end
    r.gx = clip16(round_shr(longint'(est[0]), OUT_SHIFT));
    r.gy = clip16(round_shr(longint'(est[1]), OUT_SHIFT));
    r.gz = clip16(round_shr(longint'(est[2]), OUT_SHIFT));
    r.used = used;
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    grav_t g, w;
    if (!rst_n) begin
      dt_q     <= DT_RESET;
      weight_q <= WEIGHT_RESET;
      mlo_q    <= MLO_RESET;
      mhi_q    <= MHI_RESET;
      est[0] = 0;
      est[1] = 0;
      est[2] = G_ONE;
      grav_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DT_STEP:  dt_q     <= cfg_wdata[15:0];
          REG_WEIGHT:   weight_q <= cfg_wdata[23:0];
          REG_MAG_LOW:  mlo_q    <= cfg_wdata[14:0];
          REG_MAG_HIGH: mhi_q    <= cfg_wdata[14:0];
          default: ;
        endcase
      end
      // Input transfer: predict
      if (in_tvalid && in_tready) begin
        predict_gravity(in_tdata, g);
        grav_q.push_back(g);
      end
      // Output transfer: compare with the oldest prediction
      if (out_tvalid && out_tready) begin
        n_results++;
        if (grav_q.size() == 0) begin
          report("results outstanding", 1, 0);
        end else begin
          w = grav_q.pop_front();
          if (w.used) n_corrected++;
          if ($signed(out_tdata[15:0]) != w.gx)
            report("grav_x", $signed(out_tdata[15:0]), w.gx);
          if ($signed(out_tdata[31:16]) != w.gy)
            report("grav_y", $signed(out_tdata[31:16]), w.gy);
          if ($signed(out_tdata[47:32]) != w.gz)
            report("grav_z", $signed(out_tdata[47:32]), w.gz);
          if (out_tuser != w.used)
            report("accel_used", out_tuser, w.used);
        end
      end
    end
  end

  initial begin
    errors = 0;
    n_results = 0;
    n_corrected = 0;
  end

endmodule

// ----- tb/gravity_vector_estimator_top_tb.sv -----
`timescale 1ns / 100ps

module gravity_vector_estimator_top_tb;
  import gve_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 900;
  localparam int N_RANDOM    = 306;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;

  int  errors, pending, n_results, n_corrected;
  int  n_sent = 0;
  int  quiet = 0;
  bit  no_gaps = 0;
  bit  held = 0;

  always #6 clk = ~clk;

  gravity_vector_estimator_top DUT (.*);

  gve_checker u_checker (.*);

  // Watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off once results flow
  initial begin
    @(posedge rst_n);
    forever begin
      int r;
      r = $urandom_range(0, 99);
      if (!held && n_results >= 300) begin
        held = 1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (no_gaps || r < 65) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else if (r < 96) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [15:0] rx, ry, rz, ax, ay, az);
    int r, gap;
    r = $urandom_range(0, 99);
    gap = (no_gaps || r < 50) ? 0 : (r < 92) ? $urandom_range(1, 4) : $urandom_range(20, 70);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {az, ay, ax, rz, ry, rx};
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  // Drop valid and let everything drain before a register write
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_rate;
    if ($urandom_range(0, 9) < 7) return 16'($signed($urandom_range(0, 4000)) - 2000);
    return 16'($urandom);
  endfunction

  // Mostly accel near 1 g in a random direction, the rest anything
  task automatic send_random;
    logic [15:0] a [3];
    real x, y, zz;
    int  j;
    if ($urandom_range(0, 9) < 7) begin
      x  = real'($signed($urandom_range(0, 5000)) - 2500);
      y  = real'($signed($urandom_range(0, 5000)) - 2500);
      zz = 16777216.0 - x * x - y * y;
      zz = (zz > 0.0) ? $sqrt(zz) : 0.0;
      if ($urandom_range(0, 1)) zz = -zz;
      for (int i = 0; i < 3; i++) begin
        j = $signed($urandom_range(0, 800)) - 400;
        a[i] = 16'(((i == 0) ? int'(x) : (i == 1) ? int'(y) : int'(zz)) + j);
      end
    end else begin
      for (int i = 0; i < 3; i++) a[i] = 16'($urandom);
    end
    send_sample(rand_rate(), rand_rate(), rand_rate(), a[0], a[1], a[2]);
  endtask

  task automatic random_run(input int n);
    for (int i = 0; i < n; i++) send_random();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: directed corners
    send_sample(0, 0, 0, 0, 0, 16'd4096);
    send_sample(0, 0, 0, 0, 0, 0);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 16'd4096);
    send_sample(16'h8000, 16'h8000, 16'h8000, 0, 0, 16'd4096);
    send_sample(0, 0, 0, 16'd2867, 0, 0);
    send_sample(0, 0, 0, 16'd2868, 0, 0);
    send_sample(0, 0, 0, 0, 16'd5325, 0);
    send_sample(0, 0, 0, 0, 16'd5324, 0);
    send_sample(0, 0, 0, 16'h8000, 16'h8000, 16'h8000);
    send_sample(0, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'd1000, 16'hFC18, 16'd500, 16'hF000, 0, 0);
    send_sample(16'd1, 16'hFFFF, 16'd1, 16'd2365, 16'd2365, 16'd2365);
    send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'hF333, 16'd1000, 16'hFC00);
    send_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    drain();

    // Largest step and weight, widest window; junk high bits and bad indexes
    write_reg(REG_DT_STEP, 24'hA5FFFF);
    write_reg(REG_WEIGHT, 24'hFFFFFF);
    write_reg(REG_MAG_LOW, 24'hFF8000);
    write_reg(REG_MAG_HIGH, 24'h007FFF);
    write_reg(3'd5, 24'h000001);
    write_reg(3'd7, 24'hFFFFFF);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000, 16'h8000, 0, 0, 16'h8000);
    send_sample(16'h8000, 16'h7FFF, 16'h8000, 0, 0, 16'd1);
    random_run(N_RANDOM);
    drain();

    // Smallest step, zero weight, narrow window, no idling
    no_gaps = 1;
    write_reg(REG_DT_STEP, 24'd1);
    write_reg(REG_WEIGHT, 24'd0);
    write_reg(REG_MAG_LOW, 24'd4000);
    write_reg(REG_MAG_HIGH, 24'd4200);
    random_run(N_RANDOM);
    drain();
    no_gaps = 0;

    // Zero step, crossed limits
    write_reg(REG_DT_STEP, 24'd0);
    write_reg(REG_WEIGHT, 24'($urandom));
    write_reg(REG_MAG_LOW, 24'd5000);
    write_reg(REG_MAG_HIGH, 24'd3000);
    random_run(N_RANDOM);
    drain();

    // Random step and weight, equal limits
    write_reg(REG_DT_STEP, 24'($urandom_range(1, 65535)));
    write_reg(REG_WEIGHT, 24'($urandom));
    write_reg(REG_MAG_LOW, 24'd4096);
    write_reg(REG_MAG_HIGH, 24'd4096);
    random_run(N_RANDOM);
    drain();

    // Back to the usual loop settings, faster blend
    write_reg(REG_DT_STEP, 24'(DT_RESET));
    write_reg(REG_WEIGHT, 24'd4000000);
    write_reg(REG_MAG_LOW, 24'(MLO_RESET));
    write_reg(REG_MAG_HIGH, 24'(MHI_RESET));
    random_run(N_RANDOM);
    drain();

    $display("sent %0d samples over six register settings, %0d results checked",
             n_sent, n_results);
    $display("accel correction applied on %0d of them", n_corrected);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
